### sv/msd_lag_correlator_unit_defines.svh
// assertion macros used by the correlator unit
`ifndef MSD_LAG_CORRELATOR_UNIT_DEFINES_SVH
`define MSD_LAG_CORRELATOR_UNIT_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define MSDC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define MSDC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/msdc_pkg.sv
package msdc_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int PART_W        = $clog2(MAX_PARTICLES);
    localparam int MAX_LENGTH    = 64;
    localparam int LAG_W         = $clog2(MAX_LENGTH);
    localparam int LEN_W         = LAG_W + 1;
    localparam int NUM_SPECIES   = 8;
    localparam int SPEC_W        = $clog2(NUM_SPECIES);
    localparam int COORD_BITS    = 24;

    // squared distance datapath
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int ACC_W  = 64;
    localparam int TICK_W = 32;

    // memories
    localparam int HIST_W      = 3 * COORD_BITS;
    localparam int HIST_ADDR_W = PART_W + LAG_W;
    localparam int HIST_DEPTH  = MAX_PARTICLES * MAX_LENGTH;
    localparam int ACC_ADDR_W  = SPEC_W + LAG_W;
    localparam int ACC_DEPTH   = NUM_SPECIES * MAX_LENGTH;

    // configuration
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_HISTORY_LENGTH = '0;
    localparam logic [LEN_W-1:0] HISTORY_LENGTH_RESET = LEN_W'(20);
    localparam logic [LEN_W-1:0] LENGTH_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LENGTH_MAX = LEN_W'(MAX_LENGTH);

    // commands carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // input tdata layout, lowest bit first
    localparam int OFF_PART = 0;
    localparam int OFF_SPEC = OFF_PART + PART_W;
    localparam int OFF_X    = OFF_SPEC + SPEC_W;
    localparam int OFF_Y    = OFF_X + COORD_BITS;
    localparam int OFF_Z    = OFF_Y + COORD_BITS;
    localparam int OFF_LAG  = OFF_Z + COORD_BITS;
    localparam int IN_FIELDS_W  = OFF_LAG + LAG_W;
    localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ACC_W + TICK_W + 1;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [LAG_W-1:0] lag;
    } lag_tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ
    } state_t;

endpackage

### sv/msdc_sqdist.sv
module msdc_sqdist (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msdc_pkg::lag_tag_t              in_tag,
    input  logic [msdc_pkg::HIST_W-1:0]     cur_pos,  // x, y, z from bit 0 up
    input  logic [msdc_pkg::HIST_W-1:0]     old_pos,  // x, y, z from bit 0 up
    output msdc_pkg::lag_tag_t              pre_tag,
    output msdc_pkg::lag_tag_t              out_tag,
    output logic [msdc_pkg::DIST_W-1:0]     out_dist
);
    import msdc_pkg::*;

    logic [2:0][DIFF_W-1:0] mag;
    logic [2:0][DIFF_W-1:0] mag_reg;
    logic [2:0][SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0]      dist_reg;
    lag_tag_t               tag1_reg;
    lag_tag_t               tag2_reg;
    lag_tag_t               tag3_reg;

    always_comb
    begin
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        logic signed [DIFF_W-1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            a = DIFF_W'(signed'(cur_pos[i*COORD_BITS +: COORD_BITS]));
            b = DIFF_W'(signed'(old_pos[i*COORD_BITS +: COORD_BITS]));
            d = a - b;
            // the most negative difference still reads right as unsigned
            mag[i] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag;
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= mag_reg[i] * mag_reg[i];
        end
        dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign pre_tag  = tag2_reg;
    assign out_tag  = tag3_reg;
    assign out_dist = dist_reg;

endmodule

### sv/msd_lag_correlator_unit.sv
// channel   role                 payload
// s_*       samples and reads    tdata: particle, species, x, y, z, lag; tuser: command;
//                                tlast: end of tick
// m_*       read results         tdata: accumulated sum, ticks taken, history full
// apb       history_length       byte address 0
//
// a sample outside the accumulating phase is taken without leaving idle; an accumulating sample
// walks the history, one read per lag, then waits in the drain state for the distance
// pipeline and the accumulator read-modify-write to empty.
// a read waits in the read state while the result register is still full and m_tready is low.
// after reset the accumulator memory is cleared one entry a cycle, all 512 entries, before the
// first transaction is taken; register writes are taken throughout.
`include "msd_lag_correlator_unit_defines.svh"

module msd_lag_correlator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // particle_index, species_index, pos_x, pos_y, pos_z, lag_to_read, zero pad
    input  logic [msdc_pkg::S_TDATA_W-1:0]      s_tdata,
    // command
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accumulated_sum, ticks_taken, history_full, zero pad
    output logic [msdc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msdc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [msdc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [msdc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import msdc_pkg::*;

    // input fields
    logic [PART_W-1:0]  in_part;
    logic [SPEC_W-1:0]  in_spec;
    logic [HIST_W-1:0]  in_pos;
    logic [LAG_W-1:0]   in_lag;
    logic               in_cmd;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LAG_W-1:0]   head_reg;
    logic [LEN_W-1:0]   fill_reg;
    logic [TICK_W-1:0]  ticks_reg;
    logic [ACC_ADDR_W-1:0] clr_cnt_reg;
    logic [LAG_W-1:0]   lag_reg;
    logic [LAG_W-1:0]   slot_reg;
    logic               m_valid_reg;

    // payload
    logic [PART_W-1:0]  part_reg;
    logic [SPEC_W-1:0]  spec_reg;
    logic [HIST_W-1:0]  cur_reg;
    logic               rd_zero_reg;
    logic [TICK_W-1:0]  rd_ticks_reg;
    logic               rd_full_reg;
    logic [ACC_W-1:0]   m_sum_reg;
    logic [TICK_W-1:0]  m_ticks_reg;
    logic               m_full_reg;

    // memories
    logic [HIST_W-1:0]  hist_mem [HIST_DEPTH];
    logic [HIST_W-1:0]  hist_rdata_reg;
    lag_tag_t           hist_tag_reg;
    logic [ACC_W-1:0]   acc_mem [ACC_DEPTH];
    logic [ACC_W-1:0]   acc_rdata_reg;

    // fsm outputs and datapath
    logic               walk_issue;
    logic               clr_we;
    logic               out_load;
    logic               s_accept;
    logic               sample_acc;
    logic               read_acc;
    logic               accumulating;
    logic               walk_last;
    logic [LAG_W-1:0]   slot_prev;
    logic               cfg_we;
    logic [LEN_W-1:0]   cfg_len;
    lag_tag_t           pre_tag;
    lag_tag_t           out_tag;
    logic [DIST_W-1:0]  out_dist;
    logic               acc_re;
    logic [ACC_ADDR_W-1:0] acc_raddr;
    logic               acc_we;
    logic [ACC_ADDR_W-1:0] acc_waddr;
    logic [ACC_W-1:0]   acc_wdata;
    logic [ACC_W:0]     acc_sum;

    assign in_cmd  = s_tuser[0];
    assign in_part = s_tdata[OFF_PART +: PART_W];
    assign in_spec = s_tdata[OFF_SPEC +: SPEC_W];
    assign in_pos  = s_tdata[OFF_X +: HIST_W];
    assign in_lag  = s_tdata[OFF_LAG +: LAG_W];

    assign s_accept   = s_tvalid && s_tready;
    assign sample_acc = s_accept && (in_cmd == CMD_SAMPLE);
    assign read_acc   = s_accept && (in_cmd == CMD_READ);

    // current sample joins the window when fill_count + 1 reaches the length
    assign accumulating = (fill_reg >= (len_reg - LEN_W'(1)));
    assign walk_last    = (LEN_W'(lag_reg) == (len_reg - LEN_W'(1)));
    assign slot_prev    = (slot_reg == '0) ? LAG_W'(len_reg - LEN_W'(1))
                                           : (slot_reg - LAG_W'(1));

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1:2] == REG_HISTORY_LENGTH);
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_HISTORY_LENGTH) ? CFG_DATA_W'(len_reg)
                                                                   : '0;

    always_comb
    begin
        logic [LEN_W-1:0] v;
        v = pwdata[LEN_W-1:0];
        priority if (v < LENGTH_MIN)
            cfg_len = LENGTH_MIN;
        else if (v > LENGTH_MAX)
            cfg_len = LENGTH_MAX;
        else
            cfg_len = v;
    end

    // control fsm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        walk_issue = 1'b0;
        clr_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_cnt_reg == ACC_ADDR_W'(ACC_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (in_cmd == CMD_READ)
                        state_next = ST_READ;
                    else if (accumulating)
                        state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                walk_issue = 1'b1;
                if (walk_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_tag.valid && out_tag.last)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring, fill, tick, clear counter, walk and result-valid bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= HISTORY_LENGTH_RESET;
            head_reg    <= '0;
            fill_reg    <= '0;
            ticks_reg   <= '0;
            clr_cnt_reg <= '0;
            lag_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_we)
                clr_cnt_reg <= clr_cnt_reg + ACC_ADDR_W'(1);
            if (cfg_we)
            begin
                len_reg  <= cfg_len;
                head_reg <= '0;
                fill_reg <= '0;
            end
            else if (sample_acc && s_tlast)
            begin
                if (accumulating && (ticks_reg != '1))
                    ticks_reg <= ticks_reg + TICK_W'(1);
                if (fill_reg < len_reg)
                    fill_reg <= fill_reg + LEN_W'(1);
                head_reg <= (LEN_W'(head_reg) == (len_reg - LEN_W'(1))) ? '0
                                                                        : (head_reg + LAG_W'(1));
            end
            if (sample_acc)
            begin
                lag_reg  <= LAG_W'(1);
                slot_reg <= (head_reg == '0) ? LAG_W'(len_reg - LEN_W'(1))
                                             : (head_reg - LAG_W'(1));
            end
            else if (walk_issue)
            begin
                lag_reg  <= lag_reg + LAG_W'(1);
                slot_reg <= slot_prev;
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            part_reg <= in_part;
            spec_reg <= in_spec;
            cur_reg  <= in_pos;
        end
        if (read_acc)
        begin
            rd_zero_reg  <= (in_lag == '0);
            rd_ticks_reg <= ticks_reg;
            rd_full_reg  <= (fill_reg >= len_reg);
        end
        if (out_load)
        begin
            m_sum_reg   <= rd_zero_reg ? '0 : acc_rdata_reg;
            m_ticks_reg <= rd_ticks_reg;
            m_full_reg  <= rd_full_reg;
        end
    end

    // history ring: sample written at the head, older slots read one lag a cycle
    always_ff @(posedge clk)
    begin
        if (sample_acc)
            hist_mem[{in_part, head_reg}] <= in_pos;
        if (walk_issue)
            hist_rdata_reg <= hist_mem[{part_reg, slot_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_tag_reg <= '0;
        else
        begin
            hist_tag_reg.valid <= walk_issue;
            hist_tag_reg.last  <= walk_last;
            hist_tag_reg.lag   <= lag_reg;
        end
    end

    msdc_sqdist u_sqdist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (hist_tag_reg),
        .cur_pos  (cur_reg),
        .old_pos  (hist_rdata_reg),
        .pre_tag  (pre_tag),
        .out_tag  (out_tag),
        .out_dist (out_dist)
    );

    // accumulator read lines up with the distance leaving the pipeline
    assign acc_re    = read_acc || pre_tag.valid;
    assign acc_raddr = read_acc ? {in_spec, in_lag} : {spec_reg, pre_tag.lag};
    assign acc_sum   = {1'b0, acc_rdata_reg} + (ACC_W + 1)'(out_dist);
    assign acc_we    = clr_we || out_tag.valid;
    assign acc_waddr = clr_we ? clr_cnt_reg : {spec_reg, out_tag.lag};
    assign acc_wdata = clr_we ? '0 : (acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        if (acc_re)
            acc_rdata_reg <= acc_mem[acc_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_full_reg, m_ticks_reg, m_sum_reg});

    `MSDC_ASSERT_ALWAYS(a_len_range, (len_reg >= LENGTH_MIN) && (len_reg <= LENGTH_MAX),
        "history length outside its range")
    `MSDC_ASSERT_ALWAYS(a_ring_bounds, (LEN_W'(head_reg) < len_reg) && (fill_reg <= len_reg),
        "ring head or fill count beyond history length")
    `MSDC_ASSERT_IMP(a_rmw_lag, out_tag.valid,
        (out_tag.lag != '0) && (LEN_W'(out_tag.lag) < len_reg),
        "accumulator update for a lag outside the window")
    `MSDC_ASSERT_IMP(a_busy_pipeline, hist_tag_reg.valid || pre_tag.valid || out_tag.valid,
        (state_reg == ST_WALK) || (state_reg == ST_DRAIN),
        "lag pipeline active while the fsm is not walking")
    `MSDC_ASSERT_IMP(a_result_source, $rose(m_valid_reg), $past(state_reg) == ST_READ,
        "result raised without a read command")

endmodule
